// ----- design/xrm_pkg.sv -----
// ============================================================================
// xrm_pkg
// Shared types and constants of the real-mode address unit.
// ============================================================================
package xrm_pkg;

    typedef enum logic [2:0] {
        CMD_FETCH   = 3'd0,
        CMD_POP     = 3'd1,
        CMD_PUSH    = 3'd2,
        CMD_MODRM   = 3'd3,
        CMD_RD      = 3'd4,
        CMD_WR      = 3'd5,
        CMD_LOAD_IP = 3'd6,
        CMD_LOAD_SP = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        RM_BX_SI = 3'd0,
        RM_BX_DI = 3'd1,
        RM_BP_SI = 3'd2,
        RM_BP_DI = 3'd3,
        RM_SI    = 3'd4,
        RM_DI    = 3'd5,
        RM_BP    = 3'd6,
        RM_BX    = 3'd7
    } rm_t;

    localparam logic [7:0]  MODRM_REG_MIN = 8'hC0;
    localparam logic [7:0]  DIRECT_MASK   = 8'hC7;
    localparam logic [7:0]  DIRECT_FORM   = 8'h06;
    localparam logic [1:0]  MOD_DISP8     = 2'b01;
    localparam logic [1:0]  MOD_DISP16    = 2'b10;
    localparam logic [15:0] STACK_STEP    = 16'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        word_size;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] seg_code;
        logic [15:0] seg_data;
        logic [15:0] seg_stack;
        logic [15:0] reg_bx;
        logic [15:0] reg_bp;
        logic [15:0] reg_si;
        logic [15:0] reg_di;
        logic [15:0] value;
    } req_t;

    // effective address result
    typedef struct packed {
        logic [15:0] seg;
        logic [15:0] off;
        logic        is_reg;
    } ea_t;

    // one decoded request, as handed to the output stage
    typedef struct packed {
        logic [15:0] seg;
        logic [15:0] off;
        logic        is_write;
        logic [15:0] data;
        logic        is_register;
        logic [2:0]  reg_index;
        logic        word;
        logic [15:0] ip_now;
        logic [15:0] sp_now;
    } access_t;

endpackage

// ----- design/xrm_if.sv -----
// ============================================================================
// xrm interfaces
// Valid/ready channels for requests and for byte bus accesses.
// ============================================================================
interface xrm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic        word_size;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] seg_code;
    logic [15:0] seg_data;
    logic [15:0] seg_stack;
    logic [15:0] reg_bx;
    logic [15:0] reg_bp;
    logic [15:0] reg_si;
    logic [15:0] reg_di;
    logic [15:0] value;

    modport source (output valid, cmd, word_size, modrm, disp, seg_code, seg_data,
                    seg_stack, reg_bx, reg_bp, reg_si, reg_di, value,
                    input ready);
    modport sink   (input valid, cmd, word_size, modrm, disp, seg_code, seg_data,
                    seg_stack, reg_bx, reg_bp, reg_si, reg_di, value,
                    output ready);
endinterface

interface xrm_acc_if;
    logic        valid;
    logic        ready;
    logic [19:0] phys_addr;
    logic [15:0] seg_out;
    logic [15:0] offset_out;
    logic        is_write;
    logic [7:0]  write_byte;
    logic        is_register;
    logic [2:0]  reg_index;
    logic        last;
    logic [15:0] ip_now;
    logic [15:0] sp_now;

    modport source (output valid, phys_addr, seg_out, offset_out, is_write, write_byte,
                    is_register, reg_index, last, ip_now, sp_now,
                    input ready);
    modport sink   (input valid, phys_addr, seg_out, offset_out, is_write, write_byte,
                    is_register, reg_index, last, ip_now, sp_now,
                    output ready);
endinterface

// ----- design/xrm_ea.sv -----
// ============================================================================
// xrm_ea
// ModRM effective address: base/index select, displacement, segment choice.
// ============================================================================
module xrm_ea (
    input  logic [7:0]   modrm,
    input  logic [15:0]  disp,
    input  logic [15:0]  seg_data,
    input  logic [15:0]  seg_stack,
    input  logic [15:0]  reg_bx,
    input  logic [15:0]  reg_bp,
    input  logic [15:0]  reg_si,
    input  logic [15:0]  reg_di,
    output xrm_pkg::ea_t ea
);
    import xrm_pkg::*;

    logic [15:0] disp_ext;
    logic [15:0] base;
    logic [15:0] index;
    logic        use_ss;

    always_comb
    begin
        if (modrm[7:6] == MOD_DISP8)
            disp_ext = {{8{disp[7]}}, disp[7:0]};
        else if (modrm[7:6] == MOD_DISP16)
            disp_ext = disp;
        else
            disp_ext = 16'd0;

        base   = 16'd0;
        index  = 16'd0;
        use_ss = 1'b0;
        case (rm_t'(modrm[2:0]))
            RM_BX_SI: begin base = reg_bx; index = reg_si; end
            RM_BX_DI: begin base = reg_bx; index = reg_di; end
            RM_BP_SI: begin base = reg_bp; index = reg_si; use_ss = 1'b1; end
            RM_BP_DI: begin base = reg_bp; index = reg_di; use_ss = 1'b1; end
            RM_SI:    index = reg_si;
            RM_DI:    index = reg_di;
            RM_BP:    begin base = reg_bp; use_ss = 1'b1; end
            RM_BX:    base = reg_bx;
            default:  base = reg_bx;
        endcase

        ea.is_reg = (modrm >= MODRM_REG_MIN);
        if ((modrm & DIRECT_MASK) == DIRECT_FORM)
        begin
            // mod 00 rm 110 is a plain 16-bit address, not bp
            ea.seg = seg_data;
            ea.off = disp;
        end
        else
        begin
            ea.seg = use_ss ? seg_stack : seg_data;
            ea.off = disp_ext + base + index;
        end
    end

endmodule

// ----- design/xrm_emit.sv -----
// ============================================================================
// xrm_emit
// Output stage: holds one decoded request and sends its one or two bytes.
// ============================================================================
module xrm_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  xrm_pkg::access_t acc,
    output logic            free,
    xrm_acc_if.source       rsp
);
    import xrm_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        phase_reg;
    logic        phase_next;
    access_t     acc_reg;
    logic [15:0] off_cur;
    logic        xfer;

    assign xfer    = rsp.valid && rsp.ready;
    assign free    = !valid_reg || (rsp.ready && rsp.last);
    assign off_cur = acc_reg.off + {15'd0, phase_reg};

    assign rsp.valid       = valid_reg;
    assign rsp.phys_addr   = {acc_reg.seg, 4'd0} + {4'd0, off_cur};
    assign rsp.seg_out     = acc_reg.seg;
    assign rsp.offset_out  = off_cur;
    assign rsp.is_write    = acc_reg.is_write;
    assign rsp.write_byte  = phase_reg ? acc_reg.data[15:8] : acc_reg.data[7:0];
    assign rsp.is_register = acc_reg.is_register;
    assign rsp.reg_index   = acc_reg.reg_index;
    assign rsp.last        = !acc_reg.word || phase_reg;
    assign rsp.ip_now      = acc_reg.ip_now;
    assign rsp.sp_now      = acc_reg.sp_now;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (xfer)
        begin
            if (rsp.last)
            begin
                valid_next = 1'b0;
                phase_next = 1'b0;
            end
            else
                phase_next = 1'b1;
        end
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            acc_reg <= acc;
    end

`ifndef NO_ASSERTIONS
    a_phase_word: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && phase_reg) |-> acc_reg.word)
        else $error("second byte on a byte access");
    a_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && !rsp.last) |=> (valid_reg && phase_reg))
        else $error("second byte of a word lost");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || (xfer && rsp.last)))
        else $error("output stage overwritten");
`endif

endmodule

// ----- design/x86_real_mode_address_unit.sv -----
// ============================================================================
// x86_real_mode_address_unit
// Address unit of a 16-bit real-mode core: pointer state and byte accesses.
// ============================================================================
// A request is taken into an input register, decoded there (pointer update,
// ModRM effective address) and moved to the output stage register, which
// sends one byte transfer per cycle while the access channel is ready:
// physical address is segment*16 + offset, cut to 20 bits. Loads of ip or sp
// produce no transfer and sustain one per cycle; byte and register-operand
// requests do so while the access channel is ready; word requests (pop and
// push are always words) hold the output stage until the second byte is sent.
module x86_real_mode_address_unit (
    input  logic      clk,
    input  logic      rst_n,
    xrm_req_if.sink   req,
    xrm_acc_if.source rsp
);
    import xrm_pkg::*;

    logic        a_valid_reg;
    req_t        a_reg;
    logic [15:0] ip_reg;
    logic [15:0] ip_next;
    logic [15:0] sp_reg;
    logic [15:0] sp_next;
    logic        a_advance;
    logic        no_result;
    logic        emit_free;
    access_t     acc;
    ea_t         ea;
    cmd_t        cmd;

    assign cmd       = cmd_t'(a_reg.cmd);
    assign no_result = (cmd == CMD_LOAD_IP) || (cmd == CMD_LOAD_SP);
    assign a_advance = a_valid_reg && (no_result || emit_free);
    assign req.ready = !a_valid_reg || a_advance;

    xrm_ea u_ea (
        .modrm     (a_reg.modrm),
        .disp      (a_reg.disp),
        .seg_data  (a_reg.seg_data),
        .seg_stack (a_reg.seg_stack),
        .reg_bx    (a_reg.reg_bx),
        .reg_bp    (a_reg.reg_bp),
        .reg_si    (a_reg.reg_si),
        .reg_di    (a_reg.reg_di),
        .ea        (ea)
    );

    always_comb
    begin
        ip_next         = ip_reg;
        sp_next         = sp_reg;
        acc.seg         = a_reg.seg_data;
        acc.off         = a_reg.disp;
        acc.is_write    = 1'b0;
        acc.data        = 16'd0;
        acc.is_register = 1'b0;
        acc.reg_index   = 3'd0;
        acc.word        = a_reg.word_size;
        case (cmd)
            CMD_FETCH:
            begin
                acc.seg = a_reg.seg_code;
                acc.off = ip_reg;
                ip_next = ip_reg + (a_reg.word_size ? 16'd2 : 16'd1);
            end
            CMD_POP:
            begin
                acc.seg  = a_reg.seg_stack;
                acc.off  = sp_reg;
                acc.word = 1'b1;
                sp_next  = sp_reg + STACK_STEP;
            end
            CMD_PUSH:
            begin
                // pre-decrement, then write at the new top
                sp_next      = sp_reg - STACK_STEP;
                acc.seg      = a_reg.seg_stack;
                acc.off      = sp_next;
                acc.is_write = 1'b1;
                acc.data     = a_reg.value;
                acc.word     = 1'b1;
            end
            CMD_MODRM:
            begin
                if (ea.is_reg)
                begin
                    acc.seg         = 16'd0;
                    acc.off         = 16'd0;
                    acc.is_register = 1'b1;
                    acc.reg_index   = a_reg.modrm[2:0];
                    acc.word        = 1'b0;
                end
                else
                begin
                    acc.seg = ea.seg;
                    acc.off = ea.off;
                end
            end
            CMD_RD: ;
            CMD_WR:
            begin
                acc.is_write = 1'b1;
                acc.data     = a_reg.value;
            end
            CMD_LOAD_IP: ip_next = a_reg.value;
            CMD_LOAD_SP: sp_next = a_reg.value;
            default: ;
        endcase
        acc.ip_now = ip_next;
        acc.sp_now = sp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            ip_reg      <= 16'd0;
            sp_reg      <= 16'd0;
        end
        else
        begin
            if (req.valid && req.ready)
                a_valid_reg <= 1'b1;
            else if (a_advance)
                a_valid_reg <= 1'b0;
            if (a_advance)
            begin
                ip_reg <= ip_next;
                sp_reg <= sp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            a_reg.cmd       <= req.cmd;
            a_reg.word_size <= req.word_size;
            a_reg.modrm     <= req.modrm;
            a_reg.disp      <= req.disp;
            a_reg.seg_code  <= req.seg_code;
            a_reg.seg_data  <= req.seg_data;
            a_reg.seg_stack <= req.seg_stack;
            a_reg.reg_bx    <= req.reg_bx;
            a_reg.reg_bp    <= req.reg_bp;
            a_reg.reg_si    <= req.reg_si;
            a_reg.reg_di    <= req.reg_di;
            a_reg.value     <= req.value;
        end
    end

    xrm_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (a_advance && !no_result),
        .acc   (acc),
        .free  (emit_free),
        .rsp   (rsp)
    );

`ifndef NO_ASSERTIONS
    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !a_advance |=> ($stable(ip_reg) && $stable(sp_reg)))
        else $error("pointer moved without a request");
    a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
        (a_advance && cmd == CMD_PUSH) |=> (sp_reg == $past(sp_reg) - STACK_STEP))
        else $error("push did not lower sp by two");
    a_reg_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_register) |-> (rsp.last && !rsp.is_write))
        else $error("register operand must be a single read");
`endif

endmodule

// ----- tb/xrm_access_checker.sv -----
// ============================================================================
// xrm_access_checker
// Watches the request and access channels of the real-mode address unit,
// predicts the byte transfers of every accepted request from its own copy of
// the instruction and stack pointers, and compares each access transfer,
// field by field, in order.
// ============================================================================
module xrm_access_checker (
    input  logic clk,
    input  logic rst_n,
    xrm_req_if   req,
    xrm_acc_if   rsp,
    output int   mismatches,
    output int   outstanding
);
    import xrm_pkg::*;

    typedef struct packed {
        logic [19:0] phys_addr;
        logic [15:0] seg;
        logic [15:0] off;
        logic        is_write;
        logic [7:0]  write_byte;
        logic        is_register;
        logic [2:0]  reg_index;
        logic        last;
        logic [15:0] ip_now;
        logic [15:0] sp_now;
    } bus_access_t;

    bus_access_t pending_accesses[$];
    logic [15:0] ip_model;
    logic [15:0] sp_model;

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
        begin
            $display("[%0t] access mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [19:0] got,
                               input logic [19:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // pointers are updated first, every transfer carries the values after the request
    task automatic predict_accesses(input req_t r);
        logic [15:0] seg;
        logic [15:0] off;
        logic [15:0] ea;
        logic        wr;
        logic        wide;
        logic        to_bus;
        bus_access_t acc;
        int          i;
        seg    = '0;
        off    = '0;
        ea     = '0;
        wr     = 1'b0;
        wide   = r.word_size;
        to_bus = 1'b1;
        acc    = '0;
        case (cmd_t'(r.cmd))
            CMD_FETCH:
            begin
                seg      = r.seg_code;
                off      = ip_model;
                ip_model = ip_model + (wide ? 16'd2 : 16'd1);
            end
            CMD_POP:
            begin
                seg      = r.seg_stack;
                off      = sp_model;
                wide     = 1'b1;
                sp_model = sp_model + STACK_STEP;
            end
            CMD_PUSH:
            begin
                sp_model = sp_model - STACK_STEP;
                seg      = r.seg_stack;
                off      = sp_model;
                wide     = 1'b1;
                wr       = 1'b1;
            end
            CMD_MODRM:
            begin
                if (r.modrm >= MODRM_REG_MIN)
                begin
                    to_bus          = 1'b0;
                    acc.is_register = 1'b1;
                    acc.reg_index   = r.modrm[2:0];
                    acc.last        = 1'b1;
                    acc.ip_now      = ip_model;
                    acc.sp_now      = sp_model;
                    pending_accesses.push_back(acc);
                end
                else if ((r.modrm & DIRECT_MASK) == DIRECT_FORM)
                begin
                    seg = r.seg_data;
                    off = r.disp;
                end
                else
                begin
                    seg = r.seg_data;
                    case (r.modrm[7:6])
                        MOD_DISP8:  ea = {{8{r.disp[7]}}, r.disp[7:0]};
                        MOD_DISP16: ea = r.disp;
                        default:    ea = '0;
                    endcase
                    case (rm_t'(r.modrm[2:0]))
                        RM_BX_SI: off = ea + r.reg_bx + r.reg_si;
                        RM_BX_DI: off = ea + r.reg_bx + r.reg_di;
                        RM_BP_SI:
                        begin
                            seg = r.seg_stack;
                            off = ea + r.reg_bp + r.reg_si;
                        end
                        RM_BP_DI:
                        begin
                            seg = r.seg_stack;
                            off = ea + r.reg_bp + r.reg_di;
                        end
                        RM_SI:    off = ea + r.reg_si;
                        RM_DI:    off = ea + r.reg_di;
                        RM_BP:
                        begin
                            seg = r.seg_stack;
                            off = ea + r.reg_bp;
                        end
                        default:  off = ea + r.reg_bx;
                    endcase
                end
            end
            CMD_RD:
            begin
                seg = r.seg_data;
                off = r.disp;
            end
            CMD_WR:
            begin
                seg = r.seg_data;
                off = r.disp;
                wr  = 1'b1;
            end
            CMD_LOAD_IP:
            begin
                ip_model = r.value;
                to_bus   = 1'b0;
            end
            default:
            begin
                sp_model = r.value;
                to_bus   = 1'b0;
            end
        endcase
        if (to_bus)
        begin
            for (i = 0; i <= int'(wide); i++)
            begin
                acc            = '0;
                acc.seg        = seg;
                acc.off        = off + 16'(i);
                acc.phys_addr  = (20'(seg) << 4) + 20'(acc.off);
                acc.is_write   = wr;
                acc.write_byte = !wr ? 8'h00 : (i == 0) ? r.value[7:0] : r.value[15:8];
                acc.last       = (i == int'(wide));
                acc.ip_now     = ip_model;
                acc.sp_now     = sp_model;
                pending_accesses.push_back(acc);
            end
        end
    endtask

    task automatic check_access();
        bus_access_t want;
        if (pending_accesses.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transfer at %0h", rsp.phys_addr));
        end
        else
        begin
            want = pending_accesses.pop_front();
            check_field("phys_addr", rsp.phys_addr, want.phys_addr);
            check_field("seg_out", 20'(rsp.seg_out), 20'(want.seg));
            check_field("offset_out", 20'(rsp.offset_out), 20'(want.off));
            check_field("is_write", 20'(rsp.is_write), 20'(want.is_write));
            check_field("write_byte", 20'(rsp.write_byte), 20'(want.write_byte));
            check_field("is_register", 20'(rsp.is_register), 20'(want.is_register));
            check_field("reg_index", 20'(rsp.reg_index), 20'(want.reg_index));
            check_field("last", 20'(rsp.last), 20'(want.last));
            check_field("ip_now", 20'(rsp.ip_now), 20'(want.ip_now));
            check_field("sp_now", 20'(rsp.sp_now), 20'(want.sp_now));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_model    = '0;
            sp_model    = '0;
            mismatches  = 0;
            pending_accesses.delete();
            outstanding <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_accesses({req.cmd, req.word_size, req.modrm, req.disp,
                                  req.seg_code, req.seg_data, req.seg_stack,
                                  req.reg_bx, req.reg_bp, req.reg_si, req.reg_di,
                                  req.value});
            end
            if (rsp.valid && rsp.ready)
            begin
                check_access();
            end
            outstanding <= pending_accesses.size();
        end
    end

endmodule

// ----- tb/tb_x86_real_mode_address_unit.sv -----
// ============================================================================
// tb_x86_real_mode_address_unit
// Drives directed and random requests into the address unit in bursts with
// random gaps, stalls the access channel on a changing pattern, and leaves
// prediction and comparison to the checker beside the block.
// ============================================================================
module tb_x86_real_mode_address_unit;
    import xrm_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   cycles = 0;

    xrm_req_if req_ch ();
    xrm_acc_if acc_ch ();

    x86_real_mode_address_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (acc_ch)
    );

    xrm_access_checker i_access_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (acc_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("x86_real_mode_address_unit regression: fail");
            $finish;
        end
    end

    // receiver stall pattern: ready follows one of four randomly chosen modes
    initial
    begin
        int mode;
        int phase;
        mode  = 0;
        phase = 0;
        acc_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (phase % 97 == 0)
            begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0:       acc_ch.ready <= 1'b1;
                1:       acc_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       acc_ch.ready <= ($urandom_range(0, 3) == 0);
                default: acc_ch.ready <= phase[2];
            endcase
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hFFFE;
            3:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic req_t make_request(cmd_t c, logic w, logic [7:0] m,
                                          logic [15:0] d, logic [15:0] v);
        req_t r;
        r.cmd       = c;
        r.word_size = w;
        r.modrm     = m;
        r.disp      = d;
        r.seg_code  = pick16();
        r.seg_data  = pick16();
        r.seg_stack = pick16();
        r.reg_bx    = pick16();
        r.reg_bp    = pick16();
        r.reg_si    = pick16();
        r.reg_di    = pick16();
        r.value     = v;
        return r;
    endfunction

    function automatic req_t random_request();
        cmd_t c;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)      c = CMD_FETCH;
        else if (roll < 27) c = CMD_POP;
        else if (roll < 39) c = CMD_PUSH;
        else if (roll < 69) c = CMD_MODRM;
        else if (roll < 78) c = CMD_RD;
        else if (roll < 89) c = CMD_WR;
        else if (roll < 94) c = CMD_LOAD_IP;
        else                c = CMD_LOAD_SP;
        return make_request(c, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            pick16(), pick16());
    endfunction

    task automatic drive_fields(input req_t r);
        req_ch.cmd       <= r.cmd;
        req_ch.word_size <= r.word_size;
        req_ch.modrm     <= r.modrm;
        req_ch.disp      <= r.disp;
        req_ch.seg_code  <= r.seg_code;
        req_ch.seg_data  <= r.seg_data;
        req_ch.seg_stack <= r.seg_stack;
        req_ch.reg_bx    <= r.reg_bx;
        req_ch.reg_bp    <= r.reg_bp;
        req_ch.reg_si    <= r.reg_si;
        req_ch.reg_di    <= r.reg_di;
        req_ch.value     <= r.value;
    endtask

    // returns at the edge where the transfer took place
    task automatic send_request(input req_t r);
        drive_fields(r);
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        req_t directed[$];
        req_t r;
        int   sent;
        int   burst;
        int   gap;
        int   k;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        drive_fields('0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pointer wrap, stack wrap, every addressing form, 20-bit cut
        directed.push_back(make_request(CMD_FETCH, 1'b0, 8'h00, 16'h0000, 16'h0000));
        directed.push_back(make_request(CMD_FETCH, 1'b1, 8'h00, 16'h0000, 16'h0000));
        directed.push_back(make_request(CMD_LOAD_IP, 1'b0, 8'h00, 16'h0000, 16'hFFFF));
        directed.push_back(make_request(CMD_FETCH, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));
        directed.push_back(make_request(CMD_PUSH, 1'b0, 8'h00, 16'h0000, 16'hA5C3));
        directed.push_back(make_request(CMD_POP, 1'b0, 8'h00, 16'h0000, 16'h0000));
        directed.push_back(make_request(CMD_LOAD_SP, 1'b1, 8'h00, 16'h0000, 16'hFFFF));
        directed.push_back(make_request(CMD_POP, 1'b1, 8'h00, 16'h0000, 16'h0000));
        directed.push_back(make_request(CMD_MODRM, 1'b1, 8'hC0, 16'h0000, 16'h0000));
        directed.push_back(make_request(CMD_MODRM, 1'b0, 8'hFF, 16'hFFFF, 16'hFFFF));
        for (k = 0; k < 8; k++)
        begin
            directed.push_back(make_request(CMD_MODRM, k[0], 8'(k), 16'hFFFF, 16'h0000));
        end
        directed.push_back(make_request(CMD_MODRM, 1'b1, 8'h40, 16'h0080, 16'h0000));
        directed.push_back(make_request(CMD_MODRM, 1'b0, 8'h7E, 16'hFF7F, 16'h0000));
        directed.push_back(make_request(CMD_MODRM, 1'b1, 8'hBE, 16'hFFFF, 16'h0000));
        r = make_request(CMD_RD, 1'b1, 8'h00, 16'hFFFF, 16'h0000);
        r.seg_data = 16'hFFFF;
        directed.push_back(r);
        r = make_request(CMD_WR, 1'b1, 8'h00, 16'hFFFF, 16'h1234);
        r.seg_data = 16'hFFFF;
        directed.push_back(r);
        directed.push_back(make_request(CMD_WR, 1'b0, 8'h00, 16'h0000, 16'hFFFF));

        foreach (directed[j])
        begin
            send_request(directed[j]);
        end
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst; k++)
            begin
                send_request(random_request());
                sent++;
            end
            if (sent % 250 < burst)
            begin
                wait_drained();
            end
            else if ($urandom_range(0, 9) < 7)
            begin
                gap = $urandom_range(1, 8);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("x86_real_mode_address_unit regression: pass");
        end
        else
        begin
            $display("x86_real_mode_address_unit regression: fail");
        end
        $finish;
    end

endmodule
